/* rtl/cubemap_face_texel_address_macros.svh */
// assertion helpers shared by the cube map texel address block
`ifndef CUBEMAP_FACE_TEXEL_ADDRESS_MACROS_SVH
`define CUBEMAP_FACE_TEXEL_ADDRESS_MACROS_SVH

// property checked on every clock edge outside reset
`define CMFTA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define CMFTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cmfta_pkg.sv */
package cmfta_pkg;

	localparam int DIR_WIDTH_DEF    = 16;
	localparam int UV_FRAC_BITS_DEF = 16;
	localparam int FACE_W           = 3;
	localparam int SIZE_W           = 13;
	localparam int TEXEL_W          = 12;
	localparam int CFG_IDX_W        = 1;

	localparam logic [SIZE_W-1:0] TEXEL_LIMIT = SIZE_W'(4096);
	localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(512);

	localparam logic [CFG_IDX_W-1:0] CFG_FACE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FACE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [FACE_W-1:0] FACE_POS_X = FACE_W'(0);
	localparam logic [FACE_W-1:0] FACE_NEG_X = FACE_W'(1);
	localparam logic [FACE_W-1:0] FACE_POS_Y = FACE_W'(2);
	localparam logic [FACE_W-1:0] FACE_NEG_Y = FACE_W'(3);
	localparam logic [FACE_W-1:0] FACE_POS_Z = FACE_W'(4);
	localparam logic [FACE_W-1:0] FACE_NEG_Z = FACE_W'(5);

	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic              zero_direction;
	} side_t;

	// zero counts as one texel, sizes past the limit are held at the limit
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] n;
		n = size;
		if (n == '0) begin
			n = SIZE_W'(1);
		end else if (n > TEXEL_LIMIT) begin
			n = TEXEL_LIMIT;
		end
		return n;
	endfunction

endpackage

/* rtl/cmfta_cfg_if.sv */
interface cmfta_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [cmfta_pkg::CFG_IDX_W-1:0] index;
	logic [cmfta_pkg::SIZE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/cmfta_dir_if.sv */
interface cmfta_dir_if #(
	parameter int DIR_WIDTH = cmfta_pkg::DIR_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [DIR_WIDTH-1:0] dir_x;
	logic signed [DIR_WIDTH-1:0] dir_y;
	logic signed [DIR_WIDTH-1:0] dir_z;

	modport source (output valid, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

/* rtl/cmfta_tex_if.sv */
interface cmfta_tex_if #(
	parameter int UV_FRAC_BITS = cmfta_pkg::UV_FRAC_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [cmfta_pkg::FACE_W-1:0]  face;
	logic [UV_FRAC_BITS:0]          u_frac;
	logic [UV_FRAC_BITS:0]          v_frac;
	logic [cmfta_pkg::TEXEL_W-1:0] texel_col;
	logic [cmfta_pkg::TEXEL_W-1:0] texel_row;
	logic                           zero_direction;

	modport source (
		output valid, face, u_frac, v_frac, texel_col, texel_row, zero_direction,
		input ready
	);
	modport sink (
		input valid, face, u_frac, v_frac, texel_col, texel_row, zero_direction,
		output ready
	);
endinterface

/* rtl/cmfta_select.sv */
module cmfta_select #(
	parameter int DIR_WIDTH = cmfta_pkg::DIR_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  logic signed [DIR_WIDTH-1:0] dir_x,
	input  logic signed [DIR_WIDTH-1:0] dir_y,
	input  logic signed [DIR_WIDTH-1:0] dir_z,
	output logic                        dn_valid,
	input  logic                        dn_ready,
	output logic [DIR_WIDTH-1:0]        ma,
	output logic [DIR_WIDTH-2:0]        rem_u,
	output logic [1:0]                  dig_u,
	output logic [DIR_WIDTH-2:0]        rem_v,
	output logic [1:0]                  dig_v,
	output cmfta_pkg::side_t            side
);
	import cmfta_pkg::*;

	logic [DIR_WIDTH-1:0]        ax, ay, az, ma_c;
	logic signed [DIR_WIDTH+1:0] xe, ye, ze, ma_e, su, sv, nu, nv;
	logic                        pos_x, pos_y, pos_z;
	side_t                       side_c;

	logic                 valid_s1;
	logic [DIR_WIDTH-1:0] ma_s1;
	logic [DIR_WIDTH:0]   nu_s1, nv_s1;
	side_t                side_s1;

	assign ax = dir_x[DIR_WIDTH-1] ? DIR_WIDTH'(-dir_x) : DIR_WIDTH'(dir_x);
	assign ay = dir_y[DIR_WIDTH-1] ? DIR_WIDTH'(-dir_y) : DIR_WIDTH'(dir_y);
	assign az = dir_z[DIR_WIDTH-1] ? DIR_WIDTH'(-dir_z) : DIR_WIDTH'(dir_z);

	assign xe = {{2{dir_x[DIR_WIDTH-1]}}, dir_x};
	assign ye = {{2{dir_y[DIR_WIDTH-1]}}, dir_y};
	assign ze = {{2{dir_z[DIR_WIDTH-1]}}, dir_z};

	assign pos_x = !dir_x[DIR_WIDTH-1] && (|dir_x);
	assign pos_y = !dir_y[DIR_WIDTH-1] && (|dir_y);
	assign pos_z = !dir_z[DIR_WIDTH-1] && (|dir_z);

	// strict x first, then y over z; a tie with z goes to z, an x-y tie to y
	always_comb begin
		side_c.zero_direction = ~|{dir_x, dir_y, dir_z};
		if (ax > ay && ax > az) begin
			ma_c        = ax;
			side_c.face = pos_x ? FACE_POS_X : FACE_NEG_X;
			su          = pos_x ? ze : -ze;
			sv          = ye;
		end else if (ay > az) begin
			ma_c        = ay;
			side_c.face = pos_y ? FACE_POS_Y : FACE_NEG_Y;
			su          = xe;
			sv          = pos_y ? ze : -ze;
		end else begin
			ma_c        = az;
			side_c.face = pos_z ? FACE_POS_Z : FACE_NEG_Z;
			su          = pos_z ? -xe : xe;
			sv          = ye;
		end
	end

	assign ma_e = {2'b00, ma_c};
	assign nu   = ma_e + su;
	assign nv   = ma_e + sv;

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			ma_s1   <= ma_c;
			nu_s1   <= nu[DIR_WIDTH:0];
			nv_s1   <= nv[DIR_WIDTH:0];
			side_s1 <= side_c;
		end
	end

	// numerator <= 2*ma, so its top bits start below the divisor
	assign dn_valid = valid_s1;
	assign ma       = ma_s1;
	assign rem_u    = nu_s1[DIR_WIDTH:2];
	assign dig_u    = nu_s1[1:0];
	assign rem_v    = nv_s1[DIR_WIDTH:2];
	assign dig_v    = nv_s1[1:0];
	assign side     = side_s1;
endmodule

/* rtl/cmfta_div_cell.sv */
module cmfta_div_cell #(
	parameter int DIR_WIDTH    = cmfta_pkg::DIR_WIDTH_DEF,
	parameter int UV_FRAC_BITS = cmfta_pkg::UV_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_ready,
	input  logic [DIR_WIDTH-1:0]   up_ma,
	input  logic [DIR_WIDTH-2:0]   up_rem_u,
	input  logic [1:0]             up_dig_u,
	input  logic [UV_FRAC_BITS:0]  up_quo_u,
	input  logic [DIR_WIDTH-2:0]   up_rem_v,
	input  logic [1:0]             up_dig_v,
	input  logic [UV_FRAC_BITS:0]  up_quo_v,
	input  cmfta_pkg::side_t       up_side,
	output logic                   dn_valid,
	input  logic                   dn_ready,
	output logic [DIR_WIDTH-1:0]   dn_ma,
	output logic [DIR_WIDTH-2:0]   dn_rem_u,
	output logic [1:0]             dn_dig_u,
	output logic [UV_FRAC_BITS:0]  dn_quo_u,
	output logic [DIR_WIDTH-2:0]   dn_rem_v,
	output logic [1:0]             dn_dig_v,
	output logic [UV_FRAC_BITS:0]  dn_quo_v,
	output cmfta_pkg::side_t       dn_side
);
	import cmfta_pkg::*;

	logic [DIR_WIDTH-1:0] trial_u, trial_v, diff_u, diff_v;
	logic                 ge_u, ge_v;

	logic                  valid_q;
	logic [DIR_WIDTH-1:0]  ma_q;
	logic [DIR_WIDTH-2:0]  rem_u_q, rem_v_q;
	logic [1:0]            dig_u_q, dig_v_q;
	logic [UV_FRAC_BITS:0] quo_u_q, quo_v_q;
	side_t                 side_q;

	// one restoring step per lane: bring down a numerator bit, subtract if it fits
	assign trial_u = {up_rem_u, up_dig_u[1]};
	assign trial_v = {up_rem_v, up_dig_v[1]};
	assign ge_u    = trial_u >= up_ma;
	assign ge_v    = trial_v >= up_ma;
	assign diff_u  = ge_u ? trial_u - up_ma : trial_u;
	assign diff_v  = ge_v ? trial_v - up_ma : trial_v;

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			ma_q    <= up_ma;
			rem_u_q <= diff_u[DIR_WIDTH-2:0];
			rem_v_q <= diff_v[DIR_WIDTH-2:0];
			dig_u_q <= {up_dig_u[0], 1'b0};
			dig_v_q <= {up_dig_v[0], 1'b0};
			quo_u_q <= {up_quo_u[UV_FRAC_BITS-1:0], ge_u};
			quo_v_q <= {up_quo_v[UV_FRAC_BITS-1:0], ge_v};
			side_q  <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_ma    = ma_q;
	assign dn_rem_u = rem_u_q;
	assign dn_dig_u = dig_u_q;
	assign dn_quo_u = quo_u_q;
	assign dn_rem_v = rem_v_q;
	assign dn_dig_v = dig_v_q;
	assign dn_quo_v = quo_v_q;
	assign dn_side  = side_q;
endmodule

/* rtl/cmfta_scale.sv */
module cmfta_scale #(
	parameter int UV_FRAC_BITS = cmfta_pkg::UV_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic [UV_FRAC_BITS:0]         quo_u,
	input  logic [UV_FRAC_BITS:0]         quo_v,
	input  cmfta_pkg::side_t              side,
	input  logic [cmfta_pkg::SIZE_W-1:0]  face_width,
	input  logic [cmfta_pkg::SIZE_W-1:0]  face_height,
	cmfta_tex_if.source                   tex_out
);
	import cmfta_pkg::*;

	localparam int PROD_W = UV_FRAC_BITS + 1 + SIZE_W;

	logic [SIZE_W-1:0] wu, hv, wu_m1, hv_m1;
	logic [PROD_W-1:0] prod_u, prod_v;
	logic [SIZE_W:0]   tu, tv, cu, cv;

	logic                  valid_q;
	logic [FACE_W-1:0]     face_q;
	logic [UV_FRAC_BITS:0] u_q, v_q;
	logic [TEXEL_W-1:0]    col_q, row_q;
	logic                  zero_q;

	assign wu    = clamp_size(face_width);
	assign hv    = clamp_size(face_height);
	assign wu_m1 = wu - SIZE_W'(1);
	assign hv_m1 = hv - SIZE_W'(1);

	assign prod_u = {{SIZE_W{1'b0}}, quo_u} * {{(UV_FRAC_BITS + 1){1'b0}}, wu};
	assign prod_v = {{SIZE_W{1'b0}}, quo_v} * {{(UV_FRAC_BITS + 1){1'b0}}, hv};
	assign tu     = prod_u[PROD_W-1:UV_FRAC_BITS];
	assign tv     = prod_v[PROD_W-1:UV_FRAC_BITS];

	// u or v of exactly one lands on the last texel
	assign cu = (tu > {1'b0, wu_m1}) ? {1'b0, wu_m1} : tu;
	assign cv = (tv > {1'b0, hv_m1}) ? {1'b0, hv_m1} : tv;

	assign up_ready = !valid_q || tex_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			zero_q <= side.zero_direction;
			if (side.zero_direction) begin
				face_q <= FACE_POS_X;
				u_q    <= '0;
				v_q    <= '0;
				col_q  <= '0;
				row_q  <= '0;
			end else begin
				face_q <= side.face;
				u_q    <= quo_u;
				v_q    <= quo_v;
				col_q  <= cu[TEXEL_W-1:0];
				row_q  <= cv[TEXEL_W-1:0];
			end
		end
	end

	assign tex_out.valid          = valid_q;
	assign tex_out.face           = face_q;
	assign tex_out.u_frac         = u_q;
	assign tex_out.v_frac         = v_q;
	assign tex_out.texel_col      = col_q;
	assign tex_out.texel_row      = row_q;
	assign tex_out.zero_direction = zero_q;
endmodule

/* rtl/cubemap_face_texel_address.sv */
// Cube map face selection and texel addressing.
// dir_in carries a direction as three signed components (Q2.14 at the default
// width); tex_out returns the cube face, u and v as unsigned Q1.16 fractions
// (one is 65536) and the texel column and row on a face of the configured size.
// cfg writes face_width (index 0) or face_height (index 1) and is always ready.
// The user must write it only while no transfer is in flight (not enforced).
// From dir_in transfer to tex_out valid an item passes the face selection
// stage, a chain of UV_FRAC_BITS + 1 restoring divide cells, one per quotient
// bit, each with a u lane and a v lane, and the texel multiply stage that
// fills the output register.
// Throughput is one transfer per cycle while tex_out is ready; each stage
// holds one item and has its own valid, so a stalled tex_out only stops the
// stages that are full and dir_in keeps accepting while an empty stage remains.
// An all-zero direction gives zero_direction set and every other field zero.
// Reset empties the pipeline and sets both face sizes to 512.
`include "cubemap_face_texel_address_macros.svh"

module cubemap_face_texel_address #(
	parameter int DIR_WIDTH    = cmfta_pkg::DIR_WIDTH_DEF,
	parameter int UV_FRAC_BITS = cmfta_pkg::UV_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cmfta_cfg_if.sink   cfg,
	cmfta_dir_if.sink   dir_in,
	cmfta_tex_if.source tex_out
);
	import cmfta_pkg::*;

	localparam int NCELL = UV_FRAC_BITS + 1;
	localparam logic [UV_FRAC_BITS:0] UV_ONE = (UV_FRAC_BITS + 1)'(1) << UV_FRAC_BITS;

	logic [SIZE_W-1:0] width_q, height_q;

	logic [NCELL:0]        ch_valid, ch_ready;
	logic [DIR_WIDTH-1:0]  ch_ma    [0:NCELL];
	logic [DIR_WIDTH-2:0]  ch_rem_u [0:NCELL];
	logic [DIR_WIDTH-2:0]  ch_rem_v [0:NCELL];
	logic [1:0]            ch_dig_u [0:NCELL];
	logic [1:0]            ch_dig_v [0:NCELL];
	logic [UV_FRAC_BITS:0] ch_quo_u [0:NCELL];
	logic [UV_FRAC_BITS:0] ch_quo_v [0:NCELL];
	side_t                 ch_side  [0:NCELL];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FACE_WIDTH: begin
					width_q <= cfg.data;
				end
				CFG_FACE_HEIGHT: begin
					height_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	cmfta_select #(
		.DIR_WIDTH (DIR_WIDTH)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dir_in.valid),
		.up_ready (dir_in.ready),
		.dir_x    (dir_in.dir_x),
		.dir_y    (dir_in.dir_y),
		.dir_z    (dir_in.dir_z),
		.dn_valid (ch_valid[0]),
		.dn_ready (ch_ready[0]),
		.ma       (ch_ma[0]),
		.rem_u    (ch_rem_u[0]),
		.dig_u    (ch_dig_u[0]),
		.rem_v    (ch_rem_v[0]),
		.dig_v    (ch_dig_v[0]),
		.side     (ch_side[0])
	);

	assign ch_quo_u[0] = '0;
	assign ch_quo_v[0] = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		cmfta_div_cell #(
			.DIR_WIDTH    (DIR_WIDTH),
			.UV_FRAC_BITS (UV_FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (ch_valid[k]),
			.up_ready (ch_ready[k]),
			.up_ma    (ch_ma[k]),
			.up_rem_u (ch_rem_u[k]),
			.up_dig_u (ch_dig_u[k]),
			.up_quo_u (ch_quo_u[k]),
			.up_rem_v (ch_rem_v[k]),
			.up_dig_v (ch_dig_v[k]),
			.up_quo_v (ch_quo_v[k]),
			.up_side  (ch_side[k]),
			.dn_valid (ch_valid[k+1]),
			.dn_ready (ch_ready[k+1]),
			.dn_ma    (ch_ma[k+1]),
			.dn_rem_u (ch_rem_u[k+1]),
			.dn_dig_u (ch_dig_u[k+1]),
			.dn_quo_u (ch_quo_u[k+1]),
			.dn_rem_v (ch_rem_v[k+1]),
			.dn_dig_v (ch_dig_v[k+1]),
			.dn_quo_v (ch_quo_v[k+1]),
			.dn_side  (ch_side[k+1])
		);
	end

	cmfta_scale #(
		.UV_FRAC_BITS (UV_FRAC_BITS)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (ch_valid[NCELL]),
		.up_ready    (ch_ready[NCELL]),
		.quo_u       (ch_quo_u[NCELL]),
		.quo_v       (ch_quo_v[NCELL]),
		.side        (ch_side[NCELL]),
		.face_width  (width_q),
		.face_height (height_q),
		.tex_out     (tex_out)
	);

	`CMFTA_ASSERT(a_zero_clears, tex_out.valid && tex_out.zero_direction |-> tex_out.face == FACE_POS_X && tex_out.u_frac == '0 && tex_out.texel_row == '0, "zero direction with nonzero result")
	`CMFTA_ASSERT(a_uv_range, tex_out.valid |-> tex_out.u_frac <= UV_ONE && tex_out.v_frac <= UV_ONE, "uv fraction above one")
	`CMFTA_ASSERT(a_col_in_face, tex_out.valid |-> SIZE_W'(tex_out.texel_col) < clamp_size(width_q), "texel column past face width")
	`CMFTA_ASSERT(a_face_code, tex_out.valid |-> tex_out.face <= FACE_NEG_Z, "face code out of range")
	`CMFTA_ASSERT(a_empty_accepts, !ch_valid[0] |-> dir_in.ready, "input stalled with empty selection stage")
	`CMFTA_ASSERT_NEXT(a_cfg_width, cfg.valid && cfg.index == CFG_FACE_WIDTH, width_q == $past(cfg.data), "face width write lost")
endmodule

/* tb/tb_cubemap_face_texel_address.sv */
module tb_cubemap_face_texel_address;
	import cmfta_pkg::*;

	localparam int UV_W      = UV_FRAC_BITS_DEF + 1;
	localparam int LATENCY   = UV_FRAC_BITS_DEF + 3;
	localparam int MAG_LIMIT = 1 << (DIR_WIDTH_DEF - 1);

	typedef logic signed [DIR_WIDTH_DEF-1:0] comp_t;

	typedef struct {
		logic [FACE_W-1:0]  face;
		logic [UV_W-1:0]    u_frac;
		logic [UV_W-1:0]    v_frac;
		logic [TEXEL_W-1:0] texel_col;
		logic [TEXEL_W-1:0] texel_row;
		logic               zero_direction;
	} texel_address_t;

	logic clk = 1'b0;
	logic arst_n;

	cmfta_cfg_if cfg_bus ();
	cmfta_dir_if dir_bus ();
	cmfta_tex_if tex_bus ();

	cubemap_face_texel_address dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.dir_in  (dir_bus),
		.tex_out (tex_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	texel_address_t pending_addresses[$];
	texel_address_t arrived_expect;
	logic [SIZE_W-1:0] face_width_now  = SIZE_RESET;
	logic [SIZE_W-1:0] face_height_now = SIZE_RESET;

	int tx_idle_pct = 15;
	int rx_idle_pct = 15;
	int hold_left = 0;
	int mismatches = 0;
	int directions_sent = 0;
	int zero_vectors_sent = 0;
	int results_checked = 0;
	int size_writes = 0;

	function automatic logic [TEXEL_W-1:0] texel_index(input logic [UV_W-1:0] frac,
		input logic [SIZE_W-1:0] size);
		longint n;
		longint t;
		n = longint'(size);
		if (n == 0)
			n = 1;
		else if (n > longint'(TEXEL_LIMIT))
			n = longint'(TEXEL_LIMIT);
		t = (longint'(frac) * n) >> UV_FRAC_BITS_DEF;
		if (t > n - 1)
			t = n - 1;
		return TEXEL_W'(t);
	endfunction

	function automatic texel_address_t predict_texel_address(input comp_t x, y, z,
		input logic [SIZE_W-1:0] w, h);
		texel_address_t r;
		int ax, ay, az, ma, s, t;
		r = '{default: '0};
		if (x == 0 && y == 0 && z == 0) begin
			r.zero_direction = 1'b1;
			return r;
		end
		ax = (x < 0) ? -int'(x) : int'(x);
		ay = (y < 0) ? -int'(y) : int'(y);
		az = (z < 0) ? -int'(z) : int'(z);
		if (ax > ay && ax > az) begin
			ma = ax;
			if (x > 0) begin
				r.face = FACE_POS_X; s = int'(z); t = int'(y);
			end else begin
				r.face = FACE_NEG_X; s = -int'(z); t = int'(y);
			end
		end else if (ay > az) begin
			ma = ay;
			if (y > 0) begin
				r.face = FACE_POS_Y; s = int'(x); t = int'(z);
			end else begin
				r.face = FACE_NEG_Y; s = int'(x); t = -int'(z);
			end
		end else begin
			ma = az;
			if (z > 0) begin
				r.face = FACE_POS_Z; s = -int'(x); t = int'(y);
			end else begin
				r.face = FACE_NEG_Z; s = int'(x); t = int'(y);
			end
		end
		r.u_frac = UV_W'((longint'(s + ma) << (UV_FRAC_BITS_DEF - 1)) / longint'(ma));
		r.v_frac = UV_W'((longint'(t + ma) << (UV_FRAC_BITS_DEF - 1)) / longint'(ma));
		r.texel_col = texel_index(r.u_frac, w);
		r.texel_row = texel_index(r.v_frac, h);
		return r;
	endfunction

	// magnitude 0..MAG_LIMIT with a random sign, the full negative only as negative
	function automatic comp_t signed_component(input int m);
		if (m == MAG_LIMIT || $urandom_range(1) == 1)
			return comp_t'(-m);
		return comp_t'(m);
	endfunction

	task automatic pick_direction(output comp_t x, y, z);
		int m, k, a;
		case ($urandom_range(19))
			0: begin
				x = '0; y = '0; z = '0;
			end
			1, 2: begin
				x = signed_component($urandom_range(3));
				y = signed_component($urandom_range(3));
				z = signed_component($urandom_range(3));
			end
			3, 4, 5, 6: begin
				// equal magnitudes to hit the tie rules
				m = $urandom_range(1, MAG_LIMIT);
				k = $urandom_range(3);
				x = signed_component(k == 0 ? $urandom_range(m) : m);
				y = signed_component(k == 1 ? $urandom_range(m) : m);
				z = signed_component(k == 2 ? $urandom_range(m) : m);
			end
			7, 8: begin
				a = $urandom_range(2);
				m = $urandom_range(MAG_LIMIT - 1, MAG_LIMIT);
				x = (a == 0) ? signed_component(m) : comp_t'($urandom);
				y = (a == 1) ? signed_component(m) : comp_t'($urandom);
				z = (a == 2) ? signed_component(m) : comp_t'($urandom);
			end
			default: begin
				x = comp_t'($urandom);
				y = comp_t'($urandom);
				z = comp_t'($urandom);
			end
		endcase
	endtask

	task automatic send_direction(input comp_t x, y, z);
		while ($urandom_range(99) < tx_idle_pct) begin
			dir_bus.valid <= 1'b0;
			@(posedge clk);
		end
		dir_bus.valid <= 1'b1;
		dir_bus.dir_x <= x;
		dir_bus.dir_y <= y;
		dir_bus.dir_z <= z;
		@(posedge clk);
		while (!dir_bus.ready)
			@(posedge clk);
		pending_addresses.push_back(
			predict_texel_address(x, y, z, face_width_now, face_height_now));
		directions_sent++;
		if (x == 0 && y == 0 && z == 0)
			zero_vectors_sent++;
	endtask

	task automatic send_random_directions(input int count);
		comp_t x, y, z;
		repeat (count) begin
			pick_direction(x, y, z);
			send_direction(x, y, z);
		end
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle;
		dir_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_addresses.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_face_size(input logic [CFG_IDX_W-1:0] index,
		input logic [SIZE_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		if (index == CFG_FACE_WIDTH)
			face_width_now = value;
		else
			face_height_now = value;
		size_writes++;
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [UV_W-1:0] expv, actv);
		if (actv !== expv) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (tex_bus.valid && tex_bus.ready) begin
				if (pending_addresses.size() == 0) begin
					$display("%0t: unexpected result transfer, expected none, actual face %0d",
						$time, tex_bus.face);
					mismatches++;
				end else begin
					arrived_expect = pending_addresses.pop_front();
					compare_field("face", UV_W'(arrived_expect.face), UV_W'(tex_bus.face));
					compare_field("u_frac", arrived_expect.u_frac, tex_bus.u_frac);
					compare_field("v_frac", arrived_expect.v_frac, tex_bus.v_frac);
					compare_field("texel_col", UV_W'(arrived_expect.texel_col),
						UV_W'(tex_bus.texel_col));
					compare_field("texel_row", UV_W'(arrived_expect.texel_row),
						UV_W'(tex_bus.texel_row));
					compare_field("zero_direction", UV_W'(arrived_expect.zero_direction),
						UV_W'(tex_bus.zero_direction));
					results_checked++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				tex_bus.ready <= 1'b0;
			end else begin
				tex_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic test_directed_vectors;
		send_direction(0, 0, 0);
		send_direction(32767, 0, 0);
		send_direction(-32768, 0, 0);
		send_direction(0, 32767, 0);
		send_direction(0, -32768, 0);
		send_direction(0, 0, 32767);
		send_direction(0, 0, -32768);
		// x level with y, then x level with z, then y level with z, then all level
		send_direction(100, 100, 0);
		send_direction(100, 0, -100);
		send_direction(0, -100, 100);
		send_direction(100, 100, 100);
		send_direction(-100, -100, -100);
		send_direction(-32768, -32768, -32768);
		send_direction(32767, -32768, 32767);
		// u and v at one and at zero
		send_direction(-1000, 1000, 1000);
		send_direction(1000, -1000, 1000);
		send_direction(1, 0, 0);
		send_direction(0, 0, 1);
		send_direction(1, -1, -1);
		send_direction(-1, 1, 0);
		send_direction(12345, -321, 4);
		settle();
	endtask

	task automatic test_face_size_sweep;
		logic [SIZE_W-1:0] widths [9];
		logic [SIZE_W-1:0] heights [9];
		widths  = '{1, 0, 4096, 8191, 4097, 3, 4095, 0, 0};
		heights = '{1, 0, 4096, 8191, 2, 4095, 1, 0, 0};
		widths[7]  = SIZE_W'($urandom_range(1, 4096));
		heights[7] = SIZE_W'($urandom_range(1, 4096));
		widths[8]  = SIZE_W'($urandom_range(0, 8191));
		heights[8] = SIZE_W'($urandom_range(0, 8191));
		for (int i = 0; i < 9; i++) begin
			write_face_size(CFG_FACE_WIDTH, widths[i]);
			write_face_size(CFG_FACE_HEIGHT, heights[i]);
			send_direction(-1000, 1000, 1000);
			send_direction(1000, -1000, -1000);
			send_random_directions(35);
			settle();
		end
	endtask

	task automatic test_random_directions;
		write_face_size(CFG_FACE_WIDTH, SIZE_RESET);
		write_face_size(CFG_FACE_HEIGHT, 640);
		send_random_directions(1000);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random_directions(300);
		tx_idle_pct = 15;
		rx_idle_pct = 15;
		settle();
	endtask

	task automatic test_output_backpressure;
		tx_idle_pct = 0;
		hold_left = 150;
		send_random_directions(100);
		tx_idle_pct = 15;
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_FACE_WIDTH;
		cfg_bus.data  = '0;
		dir_bus.valid = 1'b0;
		dir_bus.dir_x = '0;
		dir_bus.dir_y = '0;
		dir_bus.dir_z = '0;
		tex_bus.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_vectors();
		test_face_size_sweep();
		test_random_directions();
		test_output_backpressure();

		settle();
		repeat (LATENCY + 4) @(posedge clk);
		$display("Covered %0d directions (%0d zero vectors), %0d face size writes,",
			directions_sent, zero_vectors_sent, size_writes);
		$display("all faces and tie cases, %0d results checked, %0d mismatches",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(12 * 200000);
		$display("%0t: timeout, %0d results still outstanding", $time,
			pending_addresses.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
